// ----- hw/rtl/one_shot_timer_bank_macros.svh -----
// Assertion macros for the one-shot timer bank.
`ifndef ONE_SHOT_TIMER_BANK_MACROS_SVH
`define ONE_SHOT_TIMER_BANK_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OSTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define OSTB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define OSTB_ASSERT(lbl, prop, msg)
`define OSTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/ostb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
package ostb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int CMD_W          = 3;
    localparam int TIMER_INDEX_W  = 4;
    localparam int COUNT_W        = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_LOAD   = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_QUERY  = 3'd5,
        CMD_SETTK  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SWEEP  = 2'd1,
        ST_APPLY  = 2'd2,
        ST_REPORT = 2'd3
    } state_t;

    typedef struct packed {
        logic step;
        logic apply;
        logic report;
        logic ok;
        logic per_timer;
        cmd_t cmd;
    } ctl_t;

endpackage

// ----- hw/rtl/ostb_ctrl.sv -----
// Sequencer: captures a command, sweeps the timers on a tick, applies, reports.
`include "one_shot_timer_bank_macros.svh"

module ostb_ctrl #(
    parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ostb_pkg::CMD_W-1:0]         s_cmd,
    input  logic [ostb_pkg::TIMER_INDEX_W-1:0] s_timer_index,
    input  logic [ostb_pkg::COUNT_W-1:0]       s_load_value,
    input  logic                              out_busy,
    output ostb_pkg::ctl_t                    ctl,
    output logic [IDX_W-1:0]                  addr,
    output logic [ostb_pkg::COUNT_W-1:0]       load_value
);
    import ostb_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [TIMER_INDEX_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0]       val_reg, val_next;
    logic                     idx_ok;
    logic                     per_timer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign idx_ok     = ({1'b0, idx_reg} < (TIMER_INDEX_W + 1)'(NUM_TIMERS));
    assign per_timer  = cmd_reg inside {[CMD_LOAD:CMD_QUERY]};
    assign load_value = val_reg;

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        s_ready       = 1'b0;
        ctl.step      = 1'b0;
        ctl.apply     = 1'b0;
        ctl.report    = 1'b0;
        ctl.ok        = idx_ok;
        ctl.per_timer = per_timer;
        ctl.cmd       = cmd_reg;
        addr          = (state_reg == ST_SWEEP) ? ptr_reg : idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next = cmd_t'(s_cmd);
                    idx_next = s_timer_index;
                    val_next = s_load_value;
                    ptr_next = '0;
                    state_next = (cmd_t'(s_cmd) == CMD_TICK) ? ST_SWEEP : ST_APPLY;
                end
            end
            ST_SWEEP: begin
                ctl.step = 1'b1;
                ptr_next = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                ctl.apply  = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (!out_busy) begin
                    ctl.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `OSTB_ASSERT(a_tick_starts_sweep, (s_valid && s_ready && s_cmd == CMD_TICK) |=> (state_reg == ST_SWEEP && ptr_reg == '0), "tick beat did not start a sweep at timer zero")
    `OSTB_ASSERT(a_sweep_ends_in_apply, (state_reg == ST_SWEEP && ptr_reg == LAST_IDX) |=> (state_reg == ST_APPLY), "sweep did not stop after the last timer")

endmodule

// ----- hw/rtl/ostb_bank.sv -----
// Timer state, tick counter and the shared decrementer.
`include "one_shot_timer_bank_macros.svh"

module ostb_bank #(
    parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ostb_pkg::ctl_t              ctl,
    input  logic [IDX_W-1:0]            addr,
    input  logic [ostb_pkg::COUNT_W-1:0] load_value,
    output logic                        rd_enabled,
    output logic                        rd_expired,
    output logic [ostb_pkg::COUNT_W-1:0] rd_count,
    output logic [ostb_pkg::COUNT_W-1:0] tick_count
);
    import ostb_pkg::*;

    logic [COUNT_W-1:0]    counts_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] done_reg;
    logic [COUNT_W-1:0]    ticks_reg, ticks_next;
    logic                  wr_en;
    logic [COUNT_W-1:0]    wr_count;
    logic                  wr_run;
    logic                  wr_done;

    assign rd_count   = counts_reg[addr];
    assign rd_enabled = running_reg[addr];
    assign rd_expired = done_reg[addr];
    assign tick_count = ticks_reg;

    always_comb begin
        ticks_next = ticks_reg;
        wr_en      = 1'b0;
        wr_count   = rd_count;
        wr_run     = rd_enabled;
        wr_done    = rd_expired;
        if (ctl.step && rd_enabled) begin
            wr_en = 1'b1;
            if (rd_count != '0) begin
                wr_count = rd_count - COUNT_W'(1);
            end else begin
                wr_done = 1'b1;
                wr_run  = 1'b0;
            end
        end
        if (ctl.apply) begin
            case (ctl.cmd)
                CMD_TICK: begin
                    ticks_next = ticks_reg + COUNT_W'(1);
                end
                CMD_SETTK: begin
                    ticks_next = load_value;
                end
                CMD_LOAD: begin
                    wr_en    = ctl.ok;
                    wr_count = load_value;
                    wr_done  = 1'b0;
                    wr_run   = 1'b1;
                end
                CMD_CLEAR: begin
                    wr_en    = ctl.ok;
                    wr_count = '0;
                    wr_done  = 1'b0;
                    wr_run   = 1'b0;
                end
                CMD_STOP: begin
                    wr_en  = ctl.ok;
                    wr_run = 1'b0;
                end
                CMD_RESUME: begin
                    wr_en  = ctl.ok;
                    wr_run = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg  <= '{default: '0};
            running_reg <= '0;
            done_reg    <= '0;
            ticks_reg   <= '0;
        end else begin
            ticks_reg <= ticks_next;
            if (wr_en) begin
                counts_reg[addr]  <= wr_count;
                running_reg[addr] <= wr_run;
                done_reg[addr]    <= wr_done;
            end
        end
    end

    `OSTB_ASSERT(a_ticks_hold, !ctl.apply |=> $stable(ticks_reg), "tick counter moved outside the apply step")

endmodule

// ----- hw/rtl/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: sequencer, timer bank, result register.
//
// A bank of NUM_TIMERS one-shot down-counting timers driven by one command per beat.
// One shared decrementer visits the timers one per cycle, so a tick command sweeps all
// NUM_TIMERS timers before the apply and report steps; every other command goes
// straight to apply and report. s_ready is high only while the sequencer is idle. The
// result register holds a finished beat while the next command is accepted; a new
// result waits only if the previous one is still not taken.
`include "one_shot_timer_bank_macros.svh"

module one_shot_timer_bank #(
    parameter int NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ostb_pkg::CMD_W-1:0]         s_cmd,
    input  logic [ostb_pkg::TIMER_INDEX_W-1:0] s_timer_index,
    input  logic [ostb_pkg::COUNT_W-1:0]       s_load_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_enabled,
    output logic                              m_expired,
    output logic [ostb_pkg::COUNT_W-1:0]       m_remaining,
    output logic [ostb_pkg::COUNT_W-1:0]       m_tick_count,
    output logic                              m_bad_index
);
    import ostb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    ctl_t               ctl;
    logic [IDX_W-1:0]   addr;
    logic [COUNT_W-1:0] load_value;
    logic               rd_enabled;
    logic               rd_expired;
    logic [COUNT_W-1:0] rd_count;
    logic [COUNT_W-1:0] tick_count;
    logic               out_busy;

    logic               m_valid_reg;
    logic               m_enabled_reg;
    logic               m_expired_reg;
    logic [COUNT_W-1:0] m_remaining_reg;
    logic [COUNT_W-1:0] m_tick_count_reg;
    logic               m_bad_index_reg;

    ostb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_timer_index (s_timer_index),
        .s_load_value  (s_load_value),
        .out_busy      (out_busy),
        .ctl           (ctl),
        .addr          (addr),
        .load_value    (load_value)
    );

    ostb_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .addr       (addr),
        .load_value (load_value),
        .rd_enabled (rd_enabled),
        .rd_expired (rd_expired),
        .rd_count   (rd_count),
        .tick_count (tick_count)
    );

    assign out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.report) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.report) begin
            m_enabled_reg    <= ctl.ok && rd_enabled;
            m_expired_reg    <= ctl.ok && rd_expired;
            m_remaining_reg  <= ctl.ok ? rd_count : '0;
            m_tick_count_reg <= tick_count;
            m_bad_index_reg  <= ctl.per_timer && !ctl.ok;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_enabled    = m_enabled_reg;
    assign m_expired    = m_expired_reg;
    assign m_remaining  = m_remaining_reg;
    assign m_tick_count = m_tick_count_reg;
    assign m_bad_index  = m_bad_index_reg;

    `OSTB_ASSERT(a_report_into_free_slot, ctl.report |-> (!m_valid || m_ready), "result beat overwrote an untaken result")
    `OSTB_ASSERT(a_valid_from_report, $rose(m_valid) |-> $past(ctl.report), "result valid rose without a report")

endmodule
